FILE: sv/nce_pkg.sv
// Shared types, constants and helpers for the coordinate extractor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package nce_pkg;

    localparam int FRACTION_DIGITS_DEF = 5;
    localparam int IDX_W               = 4;
    localparam int CFG_IDX_W           = 1;
    localparam int FRAC_W              = 24;   // holds 10^7 - 1
    localparam int DEG_W               = 10;   // up to three degree digits
    localparam int MINS_W              = 7;
    localparam int COORD_W             = 34;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_IDX  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_IDX = 1'b1;

    localparam logic [IDX_W-1:0] FIRST_IDX_RST  = 4'd4;
    localparam logic [IDX_W-1:0] SECOND_IDX_RST = 4'd6;
    localparam logic [IDX_W-1:0] MAX_TOKENS     = 4'd15;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Unconverted coordinate captured at token end; fields are zero when not ok.
    typedef struct packed {
        logic              ok;
        logic [DEG_W-1:0]  deg;
        logic [MINS_W-1:0] mins;
        logic [FRAC_W-1:0] fpad;   // fraction padded to FRACTION_DIGITS digits
    } coord_raw_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic out_en;
    } pipe_en_t;

    function automatic logic [FRAC_W-1:0] pow10(input int n);
        logic [FRAC_W-1:0] p;
        p = FRAC_W'(1);
        for (int i = 0; i < 7; i++)
        begin
            if (i < n)
                p = FRAC_W'(p * FRAC_W'(10));
        end
        return p;
    endfunction

endpackage

FILE: sv/nmea_coordinate_extractor_top.sv
// Coordinate extractor top: config registers, parser, result pipeline.
// A result is registered in stage 1, stage 2, stage 3 and the output stage before it is offered.
// Throughput: one byte per cycle; the result pipeline fills its free slots,
// so input stalls only when all four result stages hold unread results.
// Reset: indices return to 4 and 6, token state and held coordinate clear.
// Depends on nce_pkg, nce_parser and nce_convert.
`timescale 1ns / 1ps

module nmea_coordinate_extractor_top #(
    parameter int FRACTION_DIGITS = nce_pkg::FRACTION_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [nce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nce_pkg::IDX_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      data_byte,
    input  logic                            frame_start,
    input  logic                            frame_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [nce_pkg::COORD_W-1:0]     first_coord,
    output logic                            first_valid,
    output logic [nce_pkg::COORD_W-1:0]     second_coord,
    output logic                            second_valid
);
    import nce_pkg::*;

    logic [IDX_W-1:0] first_idx_reg, second_idx_reg;
    logic             accept;
    logic             emit;
    coord_raw_t       first_raw, second_raw;
    coord_raw_t       first_s1_reg, second_s1_reg;
    logic             v1_reg, v2_reg, v3_reg, vo_reg;
    logic             en1;
    pipe_en_t         en;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_idx_reg  <= FIRST_IDX_RST;
            second_idx_reg <= SECOND_IDX_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FIRST_IDX:  first_idx_reg  <= cfg_data;
                REG_SECOND_IDX: second_idx_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        en.out_en = !vo_reg || out_ready;
        en.s3     = !v3_reg || en.out_en;
        en.s2     = !v2_reg || en.s3;
        en1       = !v1_reg || en.s2;
    end

    assign in_ready = en1;
    assign accept   = in_valid && en1;

    nce_parser #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .frame_end   (frame_end),
        .first_idx   (first_idx_reg),
        .second_idx  (second_idx_reg),
        .emit        (emit),
        .first_raw   (first_raw),
        .second_raw  (second_raw)
    );

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            first_s1_reg  <= first_raw;
            second_s1_reg <= second_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= accept && emit;
            if (en.s2)
                v2_reg <= v1_reg;
            if (en.s3)
                v3_reg <= v2_reg;
            if (en.out_en)
                vo_reg <= v3_reg;
        end
    end

    nce_convert #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_conv_first (
        .clk   (clk),
        .en    (en),
        .raw   (first_s1_reg),
        .coord (first_coord),
        .ok    (first_valid)
    );

    nce_convert #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_conv_second (
        .clk   (clk),
        .en    (en),
        .raw   (second_s1_reg),
        .coord (second_coord),
        .ok    (second_valid)
    );

    assign out_valid = vo_reg;

endmodule

FILE: sv/nce_parser.sv
// Byte-wise tokenizer: splits the frame at commas and accumulates ddmm.mmmm digits.
// Holds the first captured coordinate; depends on nce_pkg.
`timescale 1ns / 1ps

module nce_parser #(
    parameter int FRACTION_DIGITS = nce_pkg::FRACTION_DIGITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [7:0]                 data_byte,
    input  logic                       frame_start,
    input  logic                       frame_end,
    input  logic [nce_pkg::IDX_W-1:0]  first_idx,
    input  logic [nce_pkg::IDX_W-1:0]  second_idx,
    output logic                       emit,
    output nce_pkg::coord_raw_t        first_raw,
    output nce_pkg::coord_raw_t        second_raw
);
    import nce_pkg::*;

    typedef struct packed {
        logic [DEG_W-1:0]  deg;
        logic [3:0]        mt;    // minutes tens digit
        logic [3:0]        mo;    // minutes ones digit
        logic [FRAC_W-1:0] fpad;
        logic [2:0]        idig;
        logic              dot;
        logic [2:0]        fdig;
        logic              bad;
    } tok_t;

    logic [IDX_W-1:0] count_reg, count_next;
    logic             in_tok_reg, in_tok_next;
    logic             done_reg, done_next;
    tok_t             tok_reg, tok_next;
    coord_raw_t       held_reg, held_next;

    function automatic tok_t take_char(input tok_t t, input logic [7:0] c);
        tok_t r;
        r = t;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            if (!t.dot)
            begin
                if (t.idig < 3'd5)
                begin
                    r.deg  = DEG_W'(14'(t.deg) * 14'd10 + 14'(t.mt));
                    r.mt   = t.mo;
                    r.mo   = c[3:0];
                    r.idig = t.idig + 3'd1;
                end
                else
                begin
                    r.idig = 3'd6;
                    r.bad  = 1'b1;
                end
            end
            else if (int'(t.fdig) < FRACTION_DIGITS)
            begin
                r.fpad = FRAC_W'(t.fpad + FRAC_W'(c[3:0])
                                 * pow10(FRACTION_DIGITS - 1 - int'(t.fdig)));
                r.fdig = t.fdig + 3'd1;
            end
        end
        else if (c == CH_DOT && !t.dot)
            r.dot = 1'b1;
        else
            r.bad = 1'b1;
        return r;
    endfunction

    function automatic coord_raw_t finish(input tok_t t);
        coord_raw_t r;
        r.ok   = t.dot && !t.bad && t.idig >= 3'd2 && t.idig <= 3'd5;
        r.deg  = r.ok ? t.deg : '0;
        r.mins = r.ok ? MINS_W'(8'(t.mt) * 8'd10 + 8'(t.mo)) : '0;
        r.fpad = r.ok ? t.fpad : '0;
        return r;
    endfunction

    always_comb
    begin
        logic       is_comma;
        logic       do_end;
        coord_raw_t cur;
        count_next  = count_reg;
        in_tok_next = in_tok_reg;
        done_next   = done_reg;
        tok_next    = tok_reg;
        held_next   = held_reg;
        emit        = 1'b0;
        do_end      = 1'b0;
        is_comma    = (data_byte == CH_COMMA);

        if (frame_start)
        begin
            count_next  = '0;
            in_tok_next = 1'b0;
            done_next   = 1'b0;
        end
        if (!done_next)
        begin
            if (is_comma)
            begin
                do_end = in_tok_next;
            end
            else
            begin
                if (!in_tok_next)
                begin
                    if (count_next == MAX_TOKENS)
                        done_next = 1'b1;
                    else
                    begin
                        count_next  = count_next + 1'b1;
                        tok_next    = '0;
                        in_tok_next = 1'b1;
                    end
                end
                if (in_tok_next)
                    tok_next = take_char(tok_next, data_byte);
                do_end = frame_end && in_tok_next && !done_next;
            end
        end

        cur = finish(tok_next);
        if (do_end)
        begin
            in_tok_next = 1'b0;
            if (count_next == first_idx)
                held_next = cur;
            if (count_next == second_idx)
            begin
                emit      = 1'b1;
                done_next = 1'b1;
            end
        end
        if (frame_end)
        begin
            done_next   = 1'b1;
            in_tok_next = 1'b0;
        end
        first_raw  = held_next;
        second_raw = cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            in_tok_reg <= 1'b0;
            done_reg   <= 1'b0;
            tok_reg    <= '0;
            held_reg   <= '0;
        end
        else if (accept)
        begin
            count_reg  <= count_next;
            in_tok_reg <= in_tok_next;
            done_reg   <= done_next;
            tok_reg    <= tok_next;
            held_reg   <= held_next;
        end
    end

endmodule

FILE: sv/nce_convert.sv
// Three-stage conversion of a captured ddmm.mmmm value to 1e-7 degree units.
// Minutes are divided by 60 through a reciprocal multiply; depends on nce_pkg.
`timescale 1ns / 1ps

module nce_convert #(
    parameter int FRACTION_DIGITS = nce_pkg::FRACTION_DIGITS_DEF
) (
    input  logic                        clk,
    input  nce_pkg::pipe_en_t           en,
    input  nce_pkg::coord_raw_t         raw,
    output logic [nce_pkg::COORD_W-1:0] coord,
    output logic                        ok
);
    import nce_pkg::*;

    localparam logic [29:0] MIN_SCALE  = 30'd10000000;
    localparam logic [29:0] FRAC_SCALE = 30'(pow10(7 - FRACTION_DIGITS));
    localparam logic [56:0] RECIP15    = 57'h11111112;   // ceil(2^32 / 15)

    logic [29:0]        m_reg, m_next;          // minutes * 10^7
    logic [COORD_W-1:0] dsc2_reg, dsc2_next;    // degrees * 10^7
    logic               ok2_reg;
    logic [23:0]        q_reg, q_next;          // minutes * 10^7 / 60
    logic [COORD_W-1:0] dsc3_reg;
    logic               ok3_reg;
    logic [COORD_W-1:0] coord_reg, coord_next;
    logic               ok_reg;
    logic [56:0]        prod;

    always_comb
    begin
        m_next     = 30'(raw.mins) * MIN_SCALE + 30'(raw.fpad) * FRAC_SCALE;
        dsc2_next  = COORD_W'(raw.deg) * COORD_W'(10000000);
        // floor(m/60) = floor(floor(m/4)/15); exact for the 28-bit quotient
        prod       = 57'(m_reg[29:2]) * RECIP15;
        q_next     = prod[55:32];
        coord_next = dsc3_reg + COORD_W'(q_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            m_reg    <= m_next;
            dsc2_reg <= dsc2_next;
            ok2_reg  <= raw.ok;
        end
        if (en.s3)
        begin
            q_reg    <= q_next;
            dsc3_reg <= dsc2_reg;
            ok3_reg  <= ok2_reg;
        end
        if (en.out_en)
        begin
            coord_reg <= coord_next;
            ok_reg    <= ok3_reg;
        end
    end

    assign coord = coord_reg;
    assign ok    = ok_reg;

endmodule
